// ===== hdl/gsca_pkg.sv =====
// Shared types and constants for the grouped sum and count aggregator.
`timescale 1ns / 1ps
package gsca_pkg;

   localparam logic [1:0] FUNC_ACCUM    = 2'd0;
   localparam logic [1:0] FUNC_FILTERED = 2'd1;
   localparam logic [1:0] FUNC_READ     = 2'd2;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   localparam logic [6:0] GROUP_COUNT_RESET   = 7'd64;
   localparam logic [3:0] VALUE_COLUMNS_RESET = 4'd1;

   localparam logic CSR_IDX_GROUP_COUNT   = 1'b0;
   localparam logic CSR_IDX_VALUE_COLUMNS = 1'b1;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] group_code;
      logic [2:0]         read_column;
      logic [7:0]         value_mask;
      logic signed [63:0] value0;
      logic signed [63:0] value1;
      logic signed [63:0] value2;
      logic signed [63:0] value3;
      logic signed [63:0] value4;
      logic signed [63:0] value5;
      logic signed [63:0] value6;
      logic signed [63:0] value7;
   } req_type;

   typedef struct packed {
      logic [31:0]        group_rows;
      logic signed [63:0] slot_sum;
      logic [31:0]        slot_count;
      logic               sum_overflow;
      logic               read_error;
   } rsp_type;

   typedef struct packed {
      logic [6:0] group_count;
      logic [3:0] value_columns;
   } cfg_type;

   typedef struct packed {
      logic [63:0] sum;
      logic [31:0] count;
      logic        overflow;
   } slot_entry_type;

   typedef struct packed {
      logic upd;
      logic clr;
   } lane_ctl_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } clr_state_type;

   function automatic logic [63:0] value_at(input req_type req, input logic [2:0] idx);
      logic [63:0] v;
      unique case (idx)
         3'd0: v = req.value0;
         3'd1: v = req.value1;
         3'd2: v = req.value2;
         3'd3: v = req.value3;
         3'd4: v = req.value4;
         3'd5: v = req.value5;
         3'd6: v = req.value6;
         3'd7: v = req.value7;
         default: v = req.value0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      return (c == CNT_MAX) ? c : c + 32'd1;
   endfunction

endpackage

// ===== hdl/gsca_csr.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module gsca_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output gsca_pkg::cfg_type  cfg
);
   import gsca_pkg::*;

   logic [6:0] group_count_ff;
   logic [6:0] group_count_in;
   logic [3:0] value_columns_ff;
   logic [3:0] value_columns_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      group_count_in   = group_count_ff;
      value_columns_in = value_columns_ff;
      if (wr_en) begin
         unique case (paddr[2])
            CSR_IDX_GROUP_COUNT:   group_count_in   = pwdata[6:0];
            CSR_IDX_VALUE_COLUMNS: value_columns_in = pwdata[3:0];
            default:               group_count_in   = group_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff   <= GROUP_COUNT_RESET;
         value_columns_ff <= VALUE_COLUMNS_RESET;
      end else begin
         group_count_ff   <= group_count_in;
         value_columns_ff <= value_columns_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_GROUP_COUNT:   prdata = {25'd0, group_count_ff};
         CSR_IDX_VALUE_COLUMNS: prdata = {28'd0, value_columns_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.group_count   = group_count_ff;
   assign cfg.value_columns = value_columns_ff;

endmodule

// ===== hdl/gsca_lane.sv =====
// One value column: per-group sum, count and overflow store with its update adder.
`timescale 1ns / 1ps
module gsca_lane #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [AW-1:0]               rd_addr,
   input  gsca_pkg::lane_ctl_type      ctl,
   input  logic [AW-1:0]               wr_addr,
   input  logic [63:0]                 value,
   output gsca_pkg::slot_entry_type    cur
);
   import gsca_pkg::*;

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;
   slot_entry_type last_data_ff;
   slot_entry_type wr_data;
   logic [AW-1:0]  last_addr_ff;
   logic           last_valid_ff;
   logic           wr_en;
   logic [63:0]    sum;

   // The previous cycle's write lands at the same edge that reads this row.
   assign cur = (last_valid_ff && last_addr_ff == wr_addr) ? last_data_ff : rd_data_ff;

   assign sum   = cur.sum + value;
   assign wr_en = ctl.upd || ctl.clr;

   always_comb begin
      if (ctl.clr) begin
         wr_data = '0;
      end else begin
         wr_data.sum      = sum;
         wr_data.count    = sat_inc(cur.count);
         wr_data.overflow = cur.overflow || (((cur.sum ^ sum) & (value ^ sum)) >> 63 != 64'd0);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
      end else begin
         last_valid_ff <= wr_en;
      end
      last_addr_ff <= wr_addr;
      last_data_ff <= wr_data;
   end

endmodule

// ===== hdl/gsca_rows.sv =====
// Per-group row count store with its saturating increment.
`timescale 1ns / 1ps
module gsca_rows #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [AW-1:0]           rd_addr,
   input  gsca_pkg::lane_ctl_type  ctl,
   input  logic [AW-1:0]           wr_addr,
   output logic [31:0]             cur
);
   import gsca_pkg::*;

   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   logic [31:0]   last_data_ff;
   logic [31:0]   wr_data;
   logic [AW-1:0] last_addr_ff;
   logic          last_valid_ff;
   logic          wr_en;

   assign cur     = (last_valid_ff && last_addr_ff == wr_addr) ? last_data_ff : rd_data_ff;
   assign wr_en   = ctl.upd || ctl.clr;
   assign wr_data = ctl.clr ? 32'd0 : sat_inc(cur);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
      end else begin
         last_valid_ff <= wr_en;
      end
      last_addr_ff <= wr_addr;
      last_data_ff <= wr_data;
   end

endmodule

// ===== hdl/grouped_sum_count_aggregator.sv =====
// Top level of the grouped sum and count aggregator.
//
//  Channel  Ports                                  Handshake
//  request  start, busy, req_payload               taken when start && !busy
//  result   rsp_valid, rsp_payload                 one-cycle strobe, no backpressure
//  config   psel, penable, pwrite, paddr, pwdata,  write in access phase, pready high
//           prdata, pready
//
// A request is taken every cycle while busy is low; a read returns its result through
// the registered store read and the result register. After reset, busy stays high
// while one row of every store is zeroed per cycle, until all MAX_GROUPS rows are
// clear. Accumulates to the same group on consecutive cycles are forwarded around
// the store. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module grouped_sum_count_aggregator #(
   parameter int MAX_GROUPS  = 64,
   parameter int MAX_COLUMNS = 8,
   parameter int MAX_SLOTS   = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gsca_pkg::req_type   req_payload,
   output logic                rsp_valid,
   output gsca_pkg::rsp_type   rsp_payload,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import gsca_pkg::*;

   localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   cfg_type        cfg;
   clr_state_type  state_ff;
   clr_state_type  state_in;
   logic [AW-1:0]  clr_addr_ff;
   logic [AW-1:0]  clr_addr_in;
   logic           clr_en;
   logic           clr_last;

   logic           accept;
   logic [31:0]    eff_groups;
   logic [3:0]     eff_cols;
   logic           group_ok;

   logic           s1_valid_ff;
   logic [1:0]     s1_func_ff;
   logic           s1_group_ok_ff;
   logic [AW-1:0]  s1_group_ff;
   logic [2:0]     s1_col_ff;
   logic [7:0]     s1_mask_ff;

   logic [AW-1:0]  wr_addr;
   logic [15:0]    slot_base;
   logic           s1_accum;
   logic           rd_ok;
   lane_ctl_type   row_ctl;
   logic [31:0]    rows_cur;
   slot_entry_type lane_cur [MAX_COLUMNS];
   slot_entry_type sel;

   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_payload_ff;
   rsp_type        rsp_payload_in;

   gsca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign clr_last = (clr_addr_ff == AW'(MAX_GROUPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_RUN;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_CLEAR: begin
            clr_en      = 1'b1;
            busy        = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_RUN: begin
            clr_en      = 1'b0;
            busy        = 1'b0;
            clr_addr_in = clr_addr_ff;
         end
         default: begin
            clr_en      = 1'b0;
            busy        = 1'b1;
            clr_addr_in = clr_addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign accept     = start && !busy;
   assign eff_groups = (32'(cfg.group_count) > 32'(MAX_GROUPS)) ?
                       32'(MAX_GROUPS) : 32'(cfg.group_count);
   assign eff_cols   = (cfg.value_columns > 4'(MAX_COLUMNS)) ?
                       4'(MAX_COLUMNS) : cfg.value_columns;
   assign group_ok   = !req_payload.group_code[31] &&
                       ($unsigned(req_payload.group_code) < eff_groups);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_func_ff     <= req_payload.func;
      s1_group_ok_ff <= group_ok;
      s1_group_ff    <= req_payload.group_code[AW-1:0];
      s1_col_ff      <= req_payload.read_column;
      s1_mask_ff     <= req_payload.value_mask;
   end

   assign wr_addr   = clr_en ? clr_addr_ff : s1_group_ff;
   assign slot_base = 16'(s1_group_ff) * 16'(MAX_COLUMNS);
   assign s1_accum  = s1_valid_ff && (s1_func_ff == FUNC_ACCUM) && s1_group_ok_ff;

   assign row_ctl.upd = s1_accum;
   assign row_ctl.clr = clr_en;

   gsca_rows #(.DEPTH(MAX_GROUPS), .AW(AW)) u_rows (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (req_payload.group_code[AW-1:0]),
      .ctl     (row_ctl),
      .wr_addr (wr_addr),
      .cur     (rows_cur)
   );

   for (genvar p = 0; p < MAX_COLUMNS; p++) begin : g_lane
      lane_ctl_type ctl;
      logic [63:0]  value_ff;

      always_ff @(posedge clock) begin
         value_ff <= value_at(req_payload, 3'(p));
      end

      assign ctl.upd = s1_accum && s1_mask_ff[p] && (4'(p) < eff_cols) &&
                       ((slot_base + 16'(p)) < 16'(MAX_SLOTS));
      assign ctl.clr = clr_en;

      gsca_lane #(.DEPTH(MAX_GROUPS), .AW(AW)) u_lane (
         .clock   (clock),
         .reset   (reset),
         .rd_addr (req_payload.group_code[AW-1:0]),
         .ctl     (ctl),
         .wr_addr (wr_addr),
         .value   (value_ff),
         .cur     (lane_cur[p])
      );
   end

   assign rd_ok = s1_group_ok_ff && (4'(s1_col_ff) < eff_cols) &&
                  ((slot_base + 16'(s1_col_ff)) < 16'(MAX_SLOTS));
   assign sel   = lane_cur[s1_col_ff[CW-1:0]];

   assign rsp_valid_in = s1_valid_ff && (s1_func_ff == FUNC_READ);

   always_comb begin
      rsp_payload_in = '0;
      if (rd_ok) begin
         rsp_payload_in.group_rows   = rows_cur;
         rsp_payload_in.slot_sum     = sel.sum;
         rsp_payload_in.slot_count   = sel.count;
         rsp_payload_in.sum_overflow = sel.overflow;
      end else begin
         rsp_payload_in.read_error   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe during clearing pass");

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result without a request taken two cycles earlier");

   a_no_item_while_clearing: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> state_ff == ST_RUN)
      else $error("request in flight during clearing pass");

   a_error_zeroes_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.read_error |->
         rsp_payload.group_rows == 32'd0 && rsp_payload.slot_count == 32'd0 &&
         rsp_payload.slot_sum == 64'sd0 && !rsp_payload.sum_overflow)
      else $error("read error result carries data");

endmodule

// ===== sim/grouped_sum_count_aggregator_test.sv =====
// Self-checking testbench that streams rows and slot reads into the aggregator.
`timescale 1ns / 1ps
module grouped_sum_count_aggregator_test;
   import gsca_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int GROUP_LIMIT = 64;
   localparam int COLUMN_LIMIT = 8;
   localparam int SLOT_LIMIT = 512;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   req_type     request_fifo[$];
   rsp_type     slot_reports[$];
   int          failures = 0;

   logic [6:0]  group_count_reg = GROUP_COUNT_RESET;
   logic [3:0]  value_columns_reg = VALUE_COLUMNS_RESET;
   logic [31:0] row_totals[GROUP_LIMIT];
   logic [63:0] sum_store[SLOT_LIMIT];
   logic [31:0] count_store[SLOT_LIMIT];
   logic        wrap_store[SLOT_LIMIT];

   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   grouped_sum_count_aggregator i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned active_groups();
      return (group_count_reg > GROUP_LIMIT) ? GROUP_LIMIT : group_count_reg;
   endfunction

   function automatic int unsigned active_columns();
      return (value_columns_reg > COLUMN_LIMIT) ? COLUMN_LIMIT : value_columns_reg;
   endfunction

   function automatic bit group_index(input logic [31:0] code, output int unsigned g);
      g = 0;
      if (code[31] || code >= active_groups()) return 1'b0;
      g = code;
      return 1'b1;
   endfunction

   function automatic logic [31:0] count_up(input logic [31:0] c);
      return (c == CNT_MAX) ? c : c + 32'd1;
   endfunction

   function automatic void queue_request(input req_type r);
      request_fifo.insert(request_fifo.size(), r);
   endfunction

   function automatic void aggregate_request(input req_type r);
      int unsigned g;
      int unsigned slot;
      bit          ok;
      logic [63:0] a;
      logic [63:0] s;
      logic [63:0] vals[COLUMN_LIMIT];
      rsp_type     rsp;
      vals = '{r.value0, r.value1, r.value2, r.value3,
               r.value4, r.value5, r.value6, r.value7};
      ok = group_index(r.group_code, g);
      case (r.func)
         FUNC_ACCUM: begin
            if (ok) begin
               row_totals[g] = count_up(row_totals[g]);
               for (int p = 0; p < active_columns(); p++) begin
                  slot = g * COLUMN_LIMIT + p;
                  if (r.value_mask[p] && slot < SLOT_LIMIT) begin
                     a = sum_store[slot];
                     s = a + vals[p];
                     if (((a ^ s) & (vals[p] ^ s)) >> 63) wrap_store[slot] = 1'b1;
                     sum_store[slot] = s;
                     count_store[slot] = count_up(count_store[slot]);
                  end
               end
            end
         end
         FUNC_READ: begin
            rsp = '0;
            slot = g * COLUMN_LIMIT + r.read_column;
            if (ok && r.read_column < active_columns() && slot < SLOT_LIMIT) begin
               rsp.group_rows = row_totals[g];
               rsp.slot_sum = sum_store[slot];
               rsp.slot_count = count_store[slot];
               rsp.sum_overflow = wrap_store[slot];
            end else begin
               rsp.read_error = 1'b1;
            end
            slot_reports.insert(slot_reports.size(), rsp);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic req_type make_req(input logic [1:0] f, input logic [31:0] code,
                                        input logic [2:0] col, input logic [7:0] mask,
                                        input logic [63:0] fill);
      req_type r;
      r.func = f;
      r.group_code = code;
      r.read_column = col;
      r.value_mask = mask;
      {r.value0, r.value1, r.value2, r.value3} = {4{fill}};
      {r.value4, r.value5, r.value6, r.value7} = {4{fill}};
      return r;
   endfunction

   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = 64'(int'($urandom_range(0, 200)) - 100);
         1: v = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
         2: v = 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
         3: v = {$urandom, $urandom} >> $urandom_range(1, 63);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   function automatic logic [31:0] wild_code(input int unsigned ng);
      logic [31:0] c;
      case ($urandom_range(0, 2))
         0: c = $urandom;
         1: c = {1'b1, 31'($urandom)};
         default: c = ng + $urandom_range(0, 3);
      endcase
      return c;
   endfunction

   function automatic req_type rand_req();
      req_type     r;
      int unsigned ng;
      int unsigned nc;
      int unsigned pick;
      ng = active_groups();
      nc = active_columns();
      pick = $urandom_range(0, 99);
      if (ng == 0 || pick >= 90) r.group_code = wild_code(ng);
      else if (pick < 45) r.group_code = $urandom_range(0, (ng < 4) ? ng - 1 : 3);
      else r.group_code = $urandom_range(0, ng - 1);
      r.value_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      r.read_column = 3'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.func = FUNC_ACCUM;
      end else if (pick < 82) begin
         r.func = FUNC_READ;
         if (nc > 0 && $urandom_range(0, 3) != 0) r.read_column = 3'($urandom_range(0, nc - 1));
      end else if (pick < 91) begin
         r.func = FUNC_FILTERED;
      end else begin
         r.func = FUNC_UNUSED;
      end
      r.value0 = rand_value();
      r.value1 = rand_value();
      r.value2 = rand_value();
      r.value3 = rand_value();
      r.value4 = rand_value();
      r.value5 = rand_value();
      r.value6 = rand_value();
      r.value7 = rand_value();
      return r;
   endfunction

   task automatic csr_write(input logic idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_IDX_GROUP_COUNT) group_count_reg = data[6:0];
      else value_columns_reg = data[3:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic settle();
      int waited;
      do @(negedge clock); while (request_fifo.size() != 0 || start);
      waited = 0;
      while (slot_reports.size() != 0 && waited < 64) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (slot_reports.size() != 0) begin
         $error("%0d expected results never arrived", slot_reports.size());
         failures++;
         slot_reports.delete();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (start && !busy) aggregate_request(req_payload);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (request_fifo.size() > 0) begin
               req_payload <= request_fifo.pop_front();
               start <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                            : $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (slot_reports.size() == 0) begin
            $error("result with no request waiting for it");
            failures++;
         end else begin
            want = slot_reports.pop_front();
            check_field("group_rows", want.group_rows, rsp_payload.group_rows);
            check_field("slot_sum", want.slot_sum, rsp_payload.slot_sum);
            check_field("slot_count", want.slot_count, rsp_payload.slot_count);
            check_field("sum_overflow", want.sum_overflow, rsp_payload.sum_overflow);
            check_field("read_error", want.read_error, rsp_payload.read_error);
         end
      end
   end

   initial begin
      int group_set[6];
      int column_set[6];
      int phase_len[6];
      group_set = '{1, 127, 0, 37, 64, 9};
      column_set = '{1, 15, 0, 5, 8, 3};
      phase_len = '{90, 110, 40, 110, 130, 100};
      foreach (row_totals[i]) row_totals[i] = '0;
      foreach (sum_store[i]) begin
         sum_store[i] = '0;
         count_store[i] = '0;
         wrap_store[i] = 1'b0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (busy !== 1'b0);

      queue_request(make_req(FUNC_READ, 0, 0, 8'h00, 64'd0));
      queue_request(make_req(FUNC_ACCUM, 5, 0, 8'hFF, 64'd7));
      queue_request(make_req(FUNC_READ, 5, 0, 8'h00, 64'd0));
      queue_request(make_req(FUNC_READ, 5, 1, 8'h00, 64'd0));
      settle();

      csr_write(CSR_IDX_GROUP_COUNT, 32'd64);
      csr_write(CSR_IDX_VALUE_COLUMNS, 32'd8);
      queue_request(make_req(FUNC_ACCUM, 63, 0, 8'hFF, 64'h7FFF_FFFF_FFFF_FFFF));
      queue_request(make_req(FUNC_ACCUM, 63, 0, 8'hFF, 64'd1));
      queue_request(make_req(FUNC_READ, 63, 7, 8'h00, 64'd0));
      queue_request(make_req(FUNC_ACCUM, 0, 0, 8'h00, 64'd9));
      queue_request(make_req(FUNC_ACCUM, 0, 0, 8'hAA, 64'h8000_0000_0000_0000));
      queue_request(make_req(FUNC_ACCUM, 0, 0, 8'hAA, 64'h8000_0000_0000_0000));
      queue_request(make_req(FUNC_READ, 0, 1, 8'h00, 64'd0));
      queue_request(make_req(FUNC_READ, 0, 0, 8'h00, 64'd0));
      queue_request(make_req(FUNC_FILTERED, 0, 1, 8'hFF, 64'd3));
      queue_request(make_req(FUNC_UNUSED, 0, 1, 8'hFF, 64'd3));
      queue_request(make_req(FUNC_ACCUM, 32'hFFFF_FFFF, 0, 8'hFF, 64'd3));
      queue_request(make_req(FUNC_ACCUM, 64, 0, 8'hFF, 64'd3));
      queue_request(make_req(FUNC_ACCUM, 32'h7FFF_FFFF, 0, 8'hFF, 64'd3));
      queue_request(make_req(FUNC_ACCUM, 32'h8000_0000, 0, 8'hFF, 64'd3));
      queue_request(make_req(FUNC_READ, 0, 1, 8'h00, 64'd0));
      queue_request(make_req(FUNC_READ, 64, 0, 8'h00, 64'd0));
      queue_request(make_req(FUNC_READ, 32'hFFFF_FFFF, 0, 8'h00, 64'd0));
      queue_request(make_req(FUNC_READ, 63, 0, 8'hFF, 64'd0));
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_IDX_GROUP_COUNT, group_set[ph]);
         csr_write(CSR_IDX_VALUE_COLUMNS, column_set[ph]);
         for (int n = 0; n < phase_len[ph]; n++) queue_request(rand_req());
         settle();
      end

      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== grouped_sum_count_aggregator.f =====
hdl/gsca_pkg.sv
hdl/gsca_csr.sv
hdl/gsca_lane.sv
hdl/gsca_rows.sv
hdl/grouped_sum_count_aggregator.sv
sim/grouped_sum_count_aggregator_test.sv
